// File: hdl/lmd_pkg.sv
package lmd_pkg;

  localparam int MAX_WIDTH       = 32;
  localparam int MAX_HEIGHT      = 4096;
  localparam int SAMPLE_BITS     = 16;
  localparam int COL_BITS        = 5;
  localparam int ROW_BITS        = 12;
  localparam int WIDTH_REG_BITS  = 6;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one column of the 3x3 window: row above, center row, row below
  typedef struct packed {
    sample_t top;
    sample_t mid;
    sample_t bot;
  } win_col_t;

  // work item flowing from the address stage into the window stage
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    sample_t             sample;
    logic                mid_ok;
    logic                top_ok;
    logic                bot_ok;
    logic                wr;
    logic                col_last;
    logic                run_end;
    logic                fdone;
    logic                fwd;
  } item_t;

  // center is m.mid; a neighbor counts only if its row and column exist
  function automatic logic is_min(win_col_t l, win_col_t m, win_col_t r,
                                  logic l_ok, logic r_ok, logic top_ok, logic bot_ok);
    logic flag;
    flag = 1'b1;
    if (top_ok && (m.top < m.mid)) flag = 1'b0;
    if (bot_ok && (m.bot < m.mid)) flag = 1'b0;
    if (l_ok) begin
      if (top_ok && (l.top < m.mid)) flag = 1'b0;
      if (l.mid < m.mid) flag = 1'b0;
      if (bot_ok && (l.bot < m.mid)) flag = 1'b0;
    end
    if (r_ok) begin
      if (top_ok && (r.top < m.mid)) flag = 1'b0;
      if (r.mid < m.mid) flag = 1'b0;
      if (bot_ok && (r.bot < m.mid)) flag = 1'b0;
    end
    return flag;
  endfunction

endpackage

// File: hdl/lmd_if.sv
interface lmd_sample_if;
  logic             valid;
  logic             ready;
  lmd_pkg::sample_t sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface lmd_result_if;
  logic                         valid;
  logic                         ready;
  lmd_pkg::sample_t             center_value;
  logic [lmd_pkg::ROW_BITS-1:0] center_row;
  logic [lmd_pkg::COL_BITS-1:0] center_column;
  logic                         is_minimum;
  logic                         last_of_run;
  logic                         frame_done;

  modport source(output valid, output center_value, output center_row,
                 output center_column, output is_minimum, output last_of_run,
                 output frame_done, input ready);
  modport sink(input valid, input center_value, input center_row,
               input center_column, input is_minimum, input last_of_run,
               input frame_done, output ready);
endinterface

interface lmd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lmd_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lmd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: hdl/local_minimum_3x3_detector_unit.sv
// channel   dir  payload                                             transfer
// samples   in   sample[15:0] signed                                 valid & ready
// results   out  center_value, center_row, center_column,            valid & ready
//                is_minimum, last_of_run, frame_done
// cfg       in   index[1:0] (0 frame_width, 1 frame_height), data    valid & ready
//
// One sample per cycle in steady state when no hold-off applies; its result passes the
// window stage register and then sits in the output register.
// A sample closing a row after the first, in a frame wider than one column, yields two
// results, so input is held off there (single output register). The last sample of a
// frame is followed by a replay of the last row out of the line memory (one read port),
// during which input is held off, as it is at the two-result row ends around it.
// rst (synchronous) clears counters and output valid and sets both sizes to 32; the
// line memory is not cleared. A stalled results channel holds any item owing a result.
module local_minimum_3x3_detector_unit (
  input  logic         clk,
  input  logic         rst,
  lmd_sample_if.sink   samples,
  lmd_result_if.source results,
  lmd_cfg_if.sink      cfg
);

  localparam int SB = lmd_pkg::SAMPLE_BITS;
  localparam int CB = lmd_pkg::COL_BITS;
  localparam int RB = lmd_pkg::ROW_BITS;
  localparam int WB = lmd_pkg::WIDTH_REG_BITS;
  localparam int HB = lmd_pkg::HEIGHT_REG_BITS;

  // configuration and frame position
  logic [WB-1:0] frame_width;
  logic [HB-1:0] frame_height;
  logic [WB-1:0] w_eff, w_m1;
  logic [HB-1:0] h_eff, h_m1;
  logic [CB-1:0] col_cnt, col_cur;
  logic [RB-1:0] row_cnt, row_cur;
  logic          burst_active;
  logic [CB-1:0] burst_col;
  logic [RB-1:0] burst_row;
  logic          cfg_hit;
  logic          col_last_in, row_last_in, frame_last;
  logic          burst_col_last;

  // address stage
  logic           a_valid, a_adv, a_take;
  lmd_pkg::item_t a_item;

  // window stage
  logic             b_valid, b_adv, phase;
  lmd_pkg::item_t   b_item;
  lmd_pkg::win_col_t win_m, win_r, new_col;
  lmd_pkg::win_col_t cl, cm;
  logic             emit1, emit2, sel2, pend, final_emit, load, flag;
  logic             l_ok;

  // line memory: per column {newer row, older row}
  logic [2*SB-1:0] line_mem [lmd_pkg::MAX_WIDTH];
  logic [2*SB-1:0] rd_word, lw_word, fresh_word, wr_word;

  // output register
  logic             out_valid, out_free;
  lmd_pkg::sample_t out_value;
  logic [RB-1:0]    out_row;
  logic [CB-1:0]    out_col;
  logic             out_min, out_last, out_done;

  always_comb begin
    if (frame_width == '0) w_eff = WB'(1);
    else if (frame_width > WB'(lmd_pkg::MAX_WIDTH)) w_eff = WB'(lmd_pkg::MAX_WIDTH);
    else w_eff = frame_width;
    if (frame_height == '0) h_eff = HB'(1);
    else if (frame_height > HB'(lmd_pkg::MAX_HEIGHT)) h_eff = HB'(lmd_pkg::MAX_HEIGHT);
    else h_eff = frame_height;
    w_m1 = w_eff - WB'(1);
    h_m1 = h_eff - HB'(1);
    col_cur = ({1'b0, col_cnt} >= w_eff) ? w_m1[CB-1:0] : col_cnt;
    row_cur = ({1'b0, row_cnt} >= h_eff) ? h_m1[RB-1:0] : row_cnt;
    col_last_in    = ({1'b0, col_cur} == w_m1);
    row_last_in    = ({1'b0, row_cur} == h_m1);
    frame_last     = col_last_in && row_last_in;
    burst_col_last = ({1'b0, burst_col} == w_m1);
  end

  assign cfg.ready = 1'b1;
  assign cfg_hit = cfg.valid &&
                   ((cfg.index == lmd_pkg::REG_FRAME_WIDTH) ||
                    (cfg.index == lmd_pkg::REG_FRAME_HEIGHT));

  // ---------------- address stage ----------------
  assign a_valid       = burst_active || samples.valid;
  assign a_adv         = !b_valid || b_adv;
  assign samples.ready = !burst_active && a_adv;
  assign a_take        = a_valid && a_adv;

  always_comb begin
    if (burst_active) begin
      // replay of the last row: the row just stored becomes the center row
      a_item.col      = burst_col;
      a_item.row      = burst_row;
      a_item.sample   = samples.sample;
      a_item.mid_ok   = 1'b1;
      a_item.top_ok   = (burst_row != '0);
      a_item.bot_ok   = 1'b0;
      a_item.wr       = 1'b0;
      a_item.col_last = burst_col_last;
      a_item.run_end  = burst_col_last;
      a_item.fdone    = burst_col_last;
    end else begin
      a_item.col      = col_cur;
      a_item.row      = row_cur - RB'(1);
      a_item.sample   = samples.sample;
      a_item.mid_ok   = (row_cur != '0);
      a_item.top_ok   = (row_cur > RB'(1));
      a_item.bot_ok   = 1'b1;
      a_item.wr       = 1'b1;
      a_item.col_last = col_last_in;
      a_item.run_end  = !frame_last;
      a_item.fdone    = 1'b0;
    end
    // write of the same column lands on the edge of this read
    a_item.fwd = b_adv && b_item.wr && (b_item.col == a_item.col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WB'(32);
      frame_height <= HB'(32);
      col_cnt      <= '0;
      row_cnt      <= '0;
      burst_active <= 1'b0;
      burst_col    <= '0;
      burst_row    <= '0;
    end else if (cfg_hit) begin
      case (cfg.index)
        lmd_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data[WB-1:0];
        lmd_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[HB-1:0];
        default: ;
      endcase
      col_cnt      <= '0;
      row_cnt      <= '0;
      burst_active <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        if (frame_last) begin
          col_cnt      <= '0;
          row_cnt      <= '0;
          burst_active <= 1'b1;
          burst_col    <= '0;
          burst_row    <= row_cur;
        end else if (col_last_in) begin
          col_cnt <= '0;
          row_cnt <= row_cur + RB'(1);
        end else begin
          col_cnt <= col_cur + CB'(1);
          row_cnt <= row_cur;
        end
      end
      if (burst_active && a_adv) begin
        burst_col <= burst_col + CB'(1);
        if (burst_col_last) burst_active <= 1'b0;
      end
    end
  end

  // ---------------- line memory ----------------
  assign fresh_word = b_item.fwd ? lw_word : rd_word;
  assign wr_word    = {b_item.sample, fresh_word[2*SB-1:SB]};

  always_ff @(posedge clk) begin
    if (a_take) rd_word <= line_mem[a_item.col];
    if (b_adv && b_item.wr) begin
      line_mem[b_item.col] <= wr_word;
      lw_word              <= wr_word;
    end
  end

  // ---------------- window stage ----------------
  always_comb begin
    new_col.top = fresh_word[SB-1:0];
    new_col.mid = fresh_word[2*SB-1:SB];
    new_col.bot = b_item.sample;

    emit1      = b_item.mid_ok && (b_item.col != '0);
    emit2      = b_item.mid_ok && b_item.col_last;
    sel2       = phase || !emit1;
    pend       = b_valid && (sel2 ? emit2 : 1'b1);
    final_emit = sel2 || !emit2;
    out_free   = !out_valid || results.ready;
    load       = pend && out_free;
    b_adv      = b_valid && (!pend || (load && final_emit));

    // first result centers on the previous column, second on the newest one
    cl   = sel2 ? win_r : win_m;
    cm   = sel2 ? new_col : win_r;
    l_ok = sel2 ? (b_item.col != '0) : (b_item.col > CB'(1));
    flag = lmd_pkg::is_min(cl, cm, new_col, l_ok, !sel2, b_item.top_ok, b_item.bot_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (a_adv) b_valid <= a_take;
      if (b_adv) phase <= 1'b0;
      else if (load) phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) b_item <= a_item;
    if (b_adv) begin
      win_m <= win_r;
      win_r <= new_col;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= cm.mid;
      out_row   <= b_item.row;
      out_col   <= sel2 ? b_item.col : b_item.col - CB'(1);
      out_min   <= flag;
      out_last  <= b_item.run_end && final_emit;
      out_done  <= b_item.fdone && final_emit;
    end
  end

  assign results.valid         = out_valid;
  assign results.center_value  = out_value;
  assign results.center_row    = out_row;
  assign results.center_column = out_col;
  assign results.is_minimum    = out_min;
  assign results.last_of_run   = out_last;
  assign results.frame_done    = out_done;

  // ---------------- checks ----------------
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> !samples.ready)
    else $error("sample taken during row replay");

  a_phase_has_second: assert property (@(posedge clk) disable iff (rst)
    phase |-> (b_valid && b_item.col_last && b_item.mid_ok))
    else $error("second result pending without a row-end item");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.frame_done) |-> results.last_of_run)
    else $error("frame end not marked as end of run");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_cnt} < w_eff))
    else $error("column counter beyond frame width");

  a_fwd_lands: assert property (@(posedge clk) disable iff (rst)
    (a_take && a_item.fwd) |=> (b_valid && (lw_word === $past(wr_word))))
    else $error("forwarded word lost");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 40;   // row replay of up to 32 columns plus pipeline
  localparam int TAIL_CYCLES   = 60;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_TARGET = 150;  // includes the power-on samples
  localparam int TALL_SAMPLES  = 24;

  localparam int MAX_WIDTH       = lmd_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT      = lmd_pkg::MAX_HEIGHT;
  localparam int ROW_BITS        = lmd_pkg::ROW_BITS;
  localparam int COL_BITS        = lmd_pkg::COL_BITS;
  localparam int WIDTH_REG_BITS  = lmd_pkg::WIDTH_REG_BITS;
  localparam int HEIGHT_REG_BITS = lmd_pkg::HEIGHT_REG_BITS;
  localparam int CFG_INDEX_BITS  = lmd_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS   = lmd_pkg::CFG_DATA_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {FULL_RANGE, NARROW, EXTREMES} fill_t;

  typedef struct packed {
    lmd_pkg::sample_t    value;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] column;
    logic                minimum;
    logic                run_end;
    logic                frame_end;
  } verdict_t;

  localparam lmd_pkg::sample_t TIE_GRID [9] = '{16'sh7fff, 16'sh0000, 16'sh0000,
                                                16'sh8000, -16'sd1,    16'sh0001,
                                                16'sh0007, 16'sh0007, 16'sh8000};

  logic clk = 1'b0;
  logic rst;

  lmd_sample_if sample_bus();
  lmd_result_if result_bus();
  lmd_cfg_if    cfg_bus();

  local_minimum_3x3_detector_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  always #HALF_PERIOD clk = ~clk;

  // window model state
  lmd_pkg::sample_t           line_mem [3][MAX_WIDTH];
  int unsigned                cur_row, cur_col, cur_slot;
  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;

  verdict_t    pending_verdicts [$];
  int unsigned fault_count = 0;
  int unsigned random_sent = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;
  int unsigned src_quiet = 0;
  int unsigned sink_quiet = 0;
  int unsigned sink_hold = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  // rows rotate through three slots; now_row lives in now_slot
  function automatic lmd_pkg::sample_t stored_px(int unsigned now_row, int unsigned now_slot,
                                                 int unsigned r, int unsigned c);
    return line_mem[(now_slot + 3 - (now_row - r) % 3) % 3][c];
  endfunction

  function automatic void add_verdict(int unsigned now_row, int unsigned now_slot,
                                      int unsigned r, int unsigned c,
                                      int unsigned w, int unsigned h,
                                      logic run_end, logic frame_end);
    verdict_t         v;
    lmd_pkg::sample_t ctr;
    int               dr, dc, nr, nc;
    logic             flag;
    ctr  = stored_px(now_row, now_slot, r, c);
    flag = 1'b1;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nr = int'(r) + dr;
        nc = int'(c) + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < int'(h) && nr <= int'(now_row) &&
            nc >= 0 && nc < int'(w)) begin
          if (stored_px(now_row, now_slot, nr, nc) < ctr) flag = 1'b0;
        end
      end
    end
    v.value     = ctr;
    v.row       = r[ROW_BITS-1:0];
    v.column    = c[COL_BITS-1:0];
    v.minimum   = flag;
    v.run_end   = run_end;
    v.frame_end = frame_end;
    pending_verdicts.push_back(v);
  endfunction

  function automatic void predict_minima(lmd_pkg::sample_t s);
    int unsigned w, h, r, c, slot, k;
    logic        closing, has_left, has_edge;
    w    = eff_width();
    h    = eff_height();
    r    = cur_row;
    c    = cur_col;
    slot = cur_slot;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    line_mem[slot][c] = s;
    closing  = (r == h - 1) && (c == w - 1);
    has_left = (r >= 1) && (c >= 1);
    has_edge = (r >= 1) && (c == w - 1);
    if (has_left) add_verdict(r, slot, r - 1, c - 1, w, h, !has_edge && !closing, 1'b0);
    if (has_edge) add_verdict(r, slot, r - 1, c, w, h, !closing, 1'b0);
    if (closing) begin
      for (k = 0; k < w; k++) add_verdict(r, slot, r, k, w, h, k == w - 1, k == w - 1);
    end
    if (closing) begin
      cur_row  = 0;
      cur_col  = 0;
      cur_slot = 0;
    end else if (c + 1 < w) begin
      cur_row = r;
      cur_col = c + 1;
    end else begin
      cur_row  = r + 1;
      cur_col  = 0;
      cur_slot = (slot + 1) % 3;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      lmd_pkg::REG_FRAME_WIDTH:  width_reg = value[WIDTH_REG_BITS-1:0];
      lmd_pkg::REG_FRAME_HEIGHT: height_reg = value[HEIGHT_REG_BITS-1:0];
      default: return;
    endcase
    cur_row  = 0;
    cur_col  = 0;
    cur_slot = 0;
  endfunction

  function automatic lmd_pkg::sample_t pick_sample(fill_t fill);
    case (fill)
      FULL_RANGE: return lmd_pkg::sample_t'($urandom);
      NARROW:     return lmd_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          default: return 16'sh0000;
        endcase
      end
    endcase
  endfunction

  // one sample transfer; valid stays high on return unless a random source pause dropped it
  task automatic push_sample(lmd_pkg::sample_t s);
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    predict_minima(s);
    if (!calm && src_quiet == 0 && $urandom_range(0, 5) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end else if (src_quiet > 0) begin
      src_quiet--;
    end else if ($urandom_range(0, 99) == 0) begin
      src_quiet = $urandom_range(20, 80);
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    sample_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_reg(idx, value);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic report_field(string field, longint want, longint got);
    fault_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_verdicts.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none actual row %0d column %0d",
                 $time, result_bus.center_row, result_bus.center_column);
      end else begin
        want = pending_verdicts.pop_front();
        if (result_bus.center_value !== want.value)
          report_field("center_value", $signed(want.value), $signed(result_bus.center_value));
        if (result_bus.center_row !== want.row)
          report_field("center_row", want.row, result_bus.center_row);
        if (result_bus.center_column !== want.column)
          report_field("center_column", want.column, result_bus.center_column);
        if (result_bus.is_minimum !== want.minimum)
          report_field("is_minimum", want.minimum, result_bus.is_minimum);
        if (result_bus.last_of_run !== want.run_end)
          report_field("last_of_run", want.run_end, result_bus.last_of_run);
        if (result_bus.frame_done !== want.frame_end)
          report_field("frame_done", want.frame_end, result_bus.frame_done);
      end
    end
  end

  // result side backpressure
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        result_bus.ready <= 1'b0;
      end else if (!calm && sink_quiet == 0 && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(0, 4);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (sink_quiet > 0) sink_quiet--;
        else if ($urandom_range(0, 99) == 0) sink_quiet = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // defaults are 32 x 32; two rows and a bit, then dropped by the next write
  task automatic test_power_on_size();
    int unsigned i;
    for (i = 0; i < 70; i++) begin
      push_sample(pick_sample(FULL_RANGE));
      random_sent++;
    end
  endtask

  task automatic test_ties_and_extremes();
    int unsigned i;
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd3);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd3);
    for (i = 0; i < 9; i++) push_sample(TIE_GRID[i]);
  endtask

  task automatic test_degenerate_sizes();
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd1);
    push_sample(16'sh5555);
    // single row frame: last pixel releases the whole row
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd4);
    push_sample(16'shaaaa);
    push_sample(16'sh5555);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
    // width field of zero, upper data bits ignored
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'h1fc0);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd2);
    push_sample(-16'sd2);
    push_sample(-16'sd3);
  endtask

  task automatic test_restart_on_write();
    int unsigned i;
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd3);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd3);
    for (i = 0; i < 4; i++) push_sample(pick_sample(NARROW));
    // unknown index: frame carries on
    write_reg(REG_SPARE_2, 13'h1fff);
    push_sample(pick_sample(NARROW));
    write_reg(REG_SPARE_3, 13'h0aaa);
    // real write drops the partial frame
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd2);
    for (i = 0; i < 6; i++) push_sample(pick_sample(EXTREMES));
  endtask

  task automatic test_random_frames();
    logic [CFG_DATA_BITS-1:0] wdata, hdata;
    int unsigned              wsel, hsel, w, h, total, frames, f, i;
    fill_t                    fill;
    while (random_sent < RANDOM_TARGET) begin
      wsel = $urandom_range(0, 11);
      wdata[CFG_DATA_BITS-1:WIDTH_REG_BITS] = (CFG_DATA_BITS-WIDTH_REG_BITS)'($urandom);
      case (wsel)
        0:       wdata[WIDTH_REG_BITS-1:0] = '0;
        1:       wdata[WIDTH_REG_BITS-1:0] = WIDTH_REG_BITS'(MAX_WIDTH);
        2:       wdata[WIDTH_REG_BITS-1:0] = WIDTH_REG_BITS'($urandom_range(33, 63));
        default: wdata[WIDTH_REG_BITS-1:0] = WIDTH_REG_BITS'($urandom_range(1, 8));
      endcase
      hsel = $urandom_range(0, 9);
      if (wsel == 1 || wsel == 2) hdata = CFG_DATA_BITS'($urandom_range(1, 2));
      else if (hsel == 0) hdata = '0;
      else if (hsel == 1) hdata = CFG_DATA_BITS'($urandom_range(MAX_HEIGHT, 8191));
      else hdata = CFG_DATA_BITS'($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 0) begin
        write_reg(lmd_pkg::REG_FRAME_WIDTH, wdata);
        write_reg(lmd_pkg::REG_FRAME_HEIGHT, hdata);
      end else begin
        write_reg(lmd_pkg::REG_FRAME_HEIGHT, hdata);
        write_reg(lmd_pkg::REG_FRAME_WIDTH, wdata);
      end
      w = eff_width();
      h = eff_height();
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        fill = fill_t'($urandom_range(0, 2));
        if (h > 64) total = w * $urandom_range(2, 4) + $urandom_range(0, w - 1);
        else if (w * h > 1 && $urandom_range(0, 7) == 0) total = $urandom_range(1, w * h - 1);
        else total = w * h;
        for (i = 0; i < total; i++) begin
          if ($urandom_range(0, 39) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_BITS'($urandom));
          push_sample(pick_sample(fill));
          random_sent++;
        end
      end
    end
  endtask

  // height above the maximum saturates; one column, partial frame dropped by the next write
  task automatic test_tall_frame();
    int unsigned i;
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'h1fff);
    for (i = 0; i < TALL_SAMPLES; i++) push_sample(pick_sample(NARROW));
  endtask

  task automatic test_full_rate();
    int unsigned i;
    calm = 1'b1;
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd32);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd2);
    for (i = 0; i < 64; i++) push_sample(pick_sample(FULL_RANGE));
    write_reg(lmd_pkg::REG_FRAME_WIDTH, 13'd2);
    write_reg(lmd_pkg::REG_FRAME_HEIGHT, 13'd3);
    for (i = 0; i < 12; i++) push_sample(pick_sample(NARROW));
    sample_bus.valid <= 1'b0;
  endtask

  initial begin
    rst              <= 1'b1;
    sample_bus.valid <= 1'b0;
    sample_bus.sample <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= lmd_pkg::REG_FRAME_WIDTH;
    cfg_bus.data     <= '0;
    width_reg  = WIDTH_REG_BITS'(MAX_WIDTH);
    height_reg = HEIGHT_REG_BITS'(32);
    cur_row    = 0;
    cur_col    = 0;
    cur_slot   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_power_on_size();
    test_ties_and_extremes();
    test_degenerate_sizes();
    test_restart_on_write();
    test_random_frames();
    test_tall_frame();
    test_full_rate();

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lmd_pkg.sv
hdl/lmd_if.sv
hdl/local_minimum_3x3_detector_unit.sv
tb/tb_top.sv
